// ===== hdl/float32_divider_assert.svh =====
// Assertion macros shared by the divider files
`ifndef FLOAT32_DIVIDER_ASSERT_SVH
`define FLOAT32_DIVIDER_ASSERT_SVH

// Implication checked on every edge outside reset
`define FD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define FD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/fdiv_pkg.sv =====
// ----------------------------------------------------------------------------
// fdiv_pkg
// Constants and types shared by the binary32 divider.
// ----------------------------------------------------------------------------
package fdiv_pkg;
    localparam logic [31:0] QNAN_DEFAULT = 32'h7FC00000;
    localparam logic [30:0] INF_MAG      = 31'h7F800000;
    localparam int          QUO_BITS     = 26;

    // Handshake between sequencer and divide unit
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } fdiv_ctl_t;
endpackage

// ===== hdl/fdiv_sigdiv.sv =====
// ----------------------------------------------------------------------------
// fdiv_sigdiv
// Radix-2 restoring significand divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fdiv_sigdiv
    import fdiv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [24:0]         num,
    input  logic [23:0]         den,
    output fdiv_ctl_t           ctl,
    output logic [QUO_BITS-1:0] quo,
    output logic                sticky
);
    `include "float32_divider_assert.svh"

    logic [25:0]         rem_reg, rem_next;
    logic [23:0]         den_reg;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next, done_reg, done_next;
    logic [25:0]         diff;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        diff      = rem_reg - {2'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, num};
            quo_next  = '0;
            cnt_next  = 5'(QUO_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[25])
            begin
                rem_next = {diff[24:0], 1'b0};
                quo_next = {quo_reg[QUO_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[24:0], 1'b0};
                quo_next = {quo_reg[QUO_BITS-2:0], 1'b0};
            end
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quo       = quo_reg;
    assign sticky    = (rem_reg != '0);

    `FD_ASSERT_NXT(a_done_ends_busy, clk, rst_n, busy_reg && cnt_reg == 5'd0 && !start, done_reg && !busy_reg)
    `FD_ASSERT_IMP(a_not_both, clk, rst_n, 1'b1, !(busy_reg && done_reg))
    `FD_ASSERT_IMP(a_no_restart, clk, rst_n, busy_reg, !start)
endmodule

// ===== hdl/float32_divider.sv =====
// ----------------------------------------------------------------------------
// float32_divider
// IEEE 754 binary32 division, round to nearest even.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: dividend, divisor with in_valid/in_ready. Output channel:
//   quotient with out_valid/out_ready. One beat in gives one beat out.
//   For normal operands the item passes a normalization check, the start of
//   the radix-2 divide unit, 26 quotient steps, the done flag and a rounding
//   step into the output register before out_valid rises. Subnormal operands
//   stay in normalization longer, shifting left one place at a time (both
//   operands shift in parallel, 23 places at most). Special operands (NaN,
//   infinity, zero) give out_valid in the cycle after acceptance. The block
//   takes one item at a time; in_ready is high only when no item is in work
//   and the output register is empty or being drained. A stalled receiver
//   holds quotient steady and blocks new input.
//   Reset clears the sequencer and out_valid; no item is in flight after.
// ----------------------------------------------------------------------------
module float32_divider
    import fdiv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] quotient
);
    `include "float32_divider_assert.svh"

    localparam logic [2:0] ST_IDLE = 3'd0, ST_NORM = 3'd1, ST_DIV = 3'd2,
                           ST_WAIT = 3'd3, ST_ROUND = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [23:0] ma_reg, mb_reg;
    logic signed [9:0] ea_reg, eb_reg, e_reg;
    logic        sign_reg;
    logic        ov_reg;
    logic [31:0] q_reg, q_next;
    logic        ov_next;
    logic        div_start;
    fdiv_ctl_t   dctl;
    logic [QUO_BITS-1:0] dquo;
    logic        dsticky;

    logic [7:0]  ae, be;
    logic [22:0] af, bf;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic        accept;

    assign ae = dividend[30:23];
    assign af = dividend[22:0];
    assign be = divisor[30:23];
    assign bf = divisor[22:0];
    assign a_nan  = (ae == 8'hFF) && (af != '0);
    assign b_nan  = (be == 8'hFF) && (bf != '0);
    assign a_inf  = (ae == 8'hFF) && (af == '0);
    assign b_inf  = (be == 8'hFF) && (bf == '0);
    assign a_zero = (ae == 8'h00) && (af == '0);
    assign b_zero = (be == 8'h00) && (bf == '0);
    assign sgn    = dividend[31] ^ divisor[31];

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid || out_ready);
    assign accept   = in_valid && in_ready;

    // Rounding datapath on the finished quotient; shift is clamped at 30 places
    logic [4:0]  sh;
    logic [31:0] qx, kept, remv, half;
    logic        up;
    logic [24:0] kr;
    logic [31:0] rres;
    always_comb
    begin
        if (e_reg >= 10'sd1)
            sh = 5'd2;
        else if (e_reg < -10'sd26)
            sh = 5'd30;
        else
            sh = 5'(10'sd3 - e_reg);
        qx   = {{(32-QUO_BITS){1'b0}}, dquo};
        kept = qx >> sh;
        remv = qx & ((32'd1 << sh) - 32'd1);
        half = 32'd1 << (sh - 5'd1);
        if (remv > half)
            up = 1'b1;
        else if (remv == half)
            up = dsticky || kept[0];
        else
            up = 1'b0;
        kr = kept[24:0] + {24'd0, up};
        if (e_reg >= 10'sd1)
        begin
            if (kr[24])
            begin
                if (e_reg + 10'sd1 >= 10'sd255)
                    rres = {sign_reg, INF_MAG};
                else
                    rres = {sign_reg, 8'(e_reg + 10'sd1), 23'd0};
            end
            else if (e_reg >= 10'sd255)
                rres = {sign_reg, INF_MAG};
            else
                rres = {sign_reg, e_reg[7:0], kr[22:0]};
        end
        else
        begin
            rres = {sign_reg, 7'd0, kr[23:0]};
        end
    end

    // Sequencer: capture (special operands answered directly), normalize, divide, round
    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg;
        q_next     = q_reg;
        div_start  = 1'b0;
        if (out_valid && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (a_nan)
                    begin
                        q_next = dividend; ov_next = 1'b1;
                    end
                    else if (b_nan)
                    begin
                        q_next = divisor; ov_next = 1'b1;
                    end
                    else if (a_inf)
                    begin
                        q_next = b_inf ? QNAN_DEFAULT : {sgn, INF_MAG}; ov_next = 1'b1;
                    end
                    else if (b_inf)
                    begin
                        q_next = {sgn, 31'd0}; ov_next = 1'b1;
                    end
                    else if (b_zero)
                    begin
                        q_next = a_zero ? QNAN_DEFAULT : {sgn, INF_MAG}; ov_next = 1'b1;
                    end
                    else if (a_zero)
                    begin
                        q_next = {sgn, 31'd0}; ov_next = 1'b1;
                    end
                    else
                        state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (ma_reg[23] && mb_reg[23])
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (dctl.done)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                q_next     = rres;
                ov_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    // Operand registers: load, then shift one bit a cycle until normalized; also result exponent and output
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        if (accept)
        begin
            sign_reg <= sgn;
            ma_reg   <= {ae != 8'd0, af};
            mb_reg   <= {be != 8'd0, bf};
            ea_reg   <= (ae != 8'd0) ? 10'(ae) : 10'sd1;
            eb_reg   <= (be != 8'd0) ? 10'(be) : 10'sd1;
        end
        else if (state_reg == ST_NORM)
        begin
            if (!ma_reg[23])
            begin
                ma_reg <= {ma_reg[22:0], 1'b0};
                ea_reg <= ea_reg - 10'sd1;
            end
            if (!mb_reg[23])
            begin
                mb_reg <= {mb_reg[22:0], 1'b0};
                eb_reg <= eb_reg - 10'sd1;
            end
        end
        if (state_reg == ST_DIV)
            e_reg <= ea_reg - eb_reg + 10'sd127 - ((ma_reg < mb_reg) ? 10'sd1 : 10'sd0);
    end

    fdiv_sigdiv u_sigdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    ((ma_reg < mb_reg) ? {ma_reg, 1'b0} : {1'b0, ma_reg}),
        .den    (mb_reg),
        .ctl    (dctl),
        .quo    (dquo),
        .sticky (dsticky)
    );

    assign out_valid = ov_reg;
    assign quotient  = q_reg;

    `FD_ASSERT_NXT(a_hold_out, clk, rst_n, out_valid && !out_ready, out_valid && $stable(quotient))
    `FD_ASSERT_IMP(a_round_after_done, clk, rst_n, state_reg == ST_ROUND, $past(dctl.done))
    `FD_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE && !dctl.busy)
endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary32 divider: a directed table of special
// operands and extremes, then random operand pairs checked against a local
// round-to-nearest-even division model, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import fdiv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 1530;
    localparam int IDLE_LIMIT = 5000;
    localparam logic [31:0] NO_CHECK = 32'h0;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic        typed;
        logic [31:0] q;
    } vec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] dividend = '0;
    logic [31:0] divisor = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] quotient;

    logic [31:0] quo_pending[$];
    int          n_errors = 0;
    int          n_checked = 0;
    int          n_sent = 0;
    int          idle_cycles = 0;

    float32_divider dut (.*);

    always #5 clk = ~clk;

    // Significand with hidden bit, exponent adjusted for subnormals
    function automatic logic [23:0] norm_sig(input logic [31:0] x, output int ex);
        logic [23:0] m;
        m  = {(x[30:23] != 0), x[22:0]};
        ex = (x[30:23] != 0) ? int'(x[30:23]) : 1;
        while (!m[23]) begin
            m  = m << 1;
            ex = ex - 1;
        end
        return m;
    endfunction

    function automatic logic [31:0] quo_of(input logic [31:0] a, input logic [31:0] b);
        logic        sg, an, bn, ai, bi, az, bz, sticky, up;
        logic [63:0] ma, mb, q, kept, rem, half;
        int          ea, eb, e, s;
        sg = a[31] ^ b[31];
        an = &a[30:23] && |a[22:0];
        bn = &b[30:23] && |b[22:0];
        ai = &a[30:23] && !(|a[22:0]);
        bi = &b[30:23] && !(|b[22:0]);
        az = a[30:0] == 0;
        bz = b[30:0] == 0;
        if (an) return a;
        if (bn) return b;
        if (ai) return bi ? QNAN_DEFAULT : {sg, INF_MAG};
        if (bi) return {sg, 31'h0};
        if (bz) return az ? QNAN_DEFAULT : {sg, INF_MAG};
        if (az) return {sg, 31'h0};
        ma = 64'(norm_sig(a, ea));
        mb = 64'(norm_sig(b, eb));
        if (ma < mb) begin
            ma = ma << 1;
            ea = ea - 1;
        end
        q      = (ma << 25) / mb;
        sticky = ((ma << 25) % mb) != 0;
        e      = ea - eb + 127;
        s      = (e >= 1) ? 2 : 3 - e;
        if (s > 30) s = 30;
        kept = q >> s;
        rem  = q & ((64'd1 << s) - 1);
        half = 64'd1 << (s - 1);
        up   = (rem > half) || (rem == half && (sticky || kept[0]));
        if (up) kept = kept + 1;
        if (e >= 1) begin
            if (kept == 64'h1000000) begin
                kept = kept >> 1;
                e = e + 1;
            end
            if (e >= 255) return {sg, INF_MAG};
            return {sg, 8'(e), kept[22:0]};
        end
        return {sg, kept[30:0]};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("tb: mismatch %s got %08h want %08h", what, got, want);
    endtask

    // Random operand with a bias toward interesting exponents
    function automatic logic [31:0] rand_operand();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(0, 9))
            0: x[30:23] = 8'h00;
            1: x[30:23] = 8'hFF;
            2: x[30:23] = 8'($urandom_range(0, 24));
            3: x[30:23] = 8'($urandom_range(230, 254));
            4: x[22:0]  = ($urandom_range(0, 1)) ? 23'h0 : 23'h7FFFFF;
            default: ;
        endcase
        return x;
    endfunction

    task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
        repeat ($urandom_range(0, 13)) @(negedge clk);
        dividend <= a;
        divisor  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Track expected quotients at each accepted input beat
    always @(posedge clk) begin
        if (in_valid && in_ready) begin
            quo_pending.push_back(quo_of(dividend, divisor));
            n_sent++;
        end
    end

    // Check each output beat against the oldest expectation
    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            n_checked++;
            if (quo_pending.size() == 0)
                report_mismatch("unexpected beat", quotient, NO_CHECK);
            else if (quotient !== quo_pending[0]) begin
                report_mismatch("quotient", quotient, quo_pending[0]);
                void'(quo_pending.pop_front());
            end else
                void'(quo_pending.pop_front());
        end
    end

    // Random receiver stalls, with calm stretches
    initial begin
        int wait_n;
        forever begin
            @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (wait_n > 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (wait_n) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted beat
    always @(posedge clk) begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end else
            idle_cycles = 0;
    end

    initial begin
        vec_t table_v[$];
        table_v = '{
            '{32'h7FC00001, 32'h3F800000, 1'b1, 32'h7FC00001},
            '{32'h3F800000, 32'hFF800123, 1'b1, 32'hFF800123},
            '{32'h7F800000, 32'hFF800000, 1'b1, 32'h7FC00000},
            '{32'h00000000, 32'h80000000, 1'b1, 32'h7FC00000},
            '{32'hFF800000, 32'h3F800000, 1'b1, 32'hFF800000},
            '{32'h7F800000, 32'h00000000, 1'b1, 32'h7F800000},
            '{32'h3F800000, 32'hFF800000, 1'b1, 32'h80000000},
            '{32'h80000000, 32'h40000000, 1'b1, 32'h80000000},
            '{32'h3F800000, 32'h00000000, 1'b1, 32'h7F800000},
            '{32'hBF800000, 32'h00000000, 1'b1, 32'hFF800000},
            '{32'h7F7FFFFF, 32'h00000001, 1'b1, 32'h7F800000},
            '{32'h00000001, 32'h7F7FFFFF, 1'b1, 32'h00000000},
            '{32'h40400000, 32'h3F800000, 1'b1, 32'h40400000},
            '{32'h3F800000, 32'h40400000, 1'b0, NO_CHECK},
            '{32'h00800000, 32'h40000000, 1'b1, 32'h00400000},
            '{32'h007FFFFF, 32'h3F7FFFFF, 1'b0, NO_CHECK},
            '{32'h00000001, 32'h3F000000, 1'b1, 32'h00000002},
            '{32'h00000001, 32'h40000000, 1'b1, 32'h00000000},
            '{32'h00000003, 32'h40000000, 1'b1, 32'h00000002},
            '{32'h7F7FFFFF, 32'h3F000000, 1'b1, 32'h7F800000},
            '{32'h007FFFFF, 32'h00000001, 1'b0, NO_CHECK},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
            '{32'h3FFFFFFF, 32'h3F800001, 1'b0, NO_CHECK}
        };
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; typed rows must agree with the model too
        foreach (table_v[i]) begin
            if (table_v[i].typed && quo_of(table_v[i].a, table_v[i].b) !== table_v[i].q)
                report_mismatch("table row", quo_of(table_v[i].a, table_v[i].b),
                                table_v[i].q);
            send_pair(table_v[i].a, table_v[i].b);
        end

        for (int i = 0; i < N_RANDOM; i++)
            send_pair(rand_operand(), rand_operand());

        // Drain, then allow for late stray beats
        while (quo_pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("tb: %0d operand pairs sent, %0d quotients checked", n_sent, n_checked);
        $display("tb: covered NaN, infinity, zero, subnormal and overflow operands");
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fdiv_pkg.sv
hdl/fdiv_sigdiv.sv
hdl/float32_divider.sv
sim/tb_top.sv
